>>> hdl/i2cbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbe_pkg
// Shared types and constants for the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

  localparam int COUNTER_WIDTH = 16;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int BYTE_W        = 8;
  localparam int Q_DEPTH       = 2;
  localparam int Q_PTR_W       = $clog2(Q_DEPTH);
  localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

  typedef logic [COUNTER_WIDTH-1:0] cnt_t;
  typedef logic [CFG_DATA_W-1:0]    cfg_data_t;
  typedef logic [BYTE_W-1:0]        byte_t;

  typedef enum logic [2:0] {
    FN_TICK     = 3'd0,
    FN_START    = 3'd1,
    FN_STOP     = 3'd2,
    FN_WR_ACK   = 3'd3,
    FN_WR_NOACK = 3'd4,
    FN_RD_ACK   = 3'd5,
    FN_RD_NACK  = 3'd6
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_DELAY  = 1'b0,
    REG_ACK_TIMEOUT = 1'b1
  } cfg_idx_t;

  // one classified tick word between front and back
  typedef struct packed {
    func_t cmd;
    byte_t data;
    logic  sda;
  } tick_word_t;

endpackage

>>> hdl/i2cbe_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbe_in_if
// Tick word channel: command, byte to send and sampled SDA.
// ----------------------------------------------------------------------------
interface i2cbe_in_if import i2cbe_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] func;
  byte_t      data_byte;
  logic       sda_sample;

  modport source (output valid, output func, output data_byte, output sda_sample,
                  input ready);
  modport sink   (input valid, input func, input data_byte, input sda_sample,
                  output ready);
endinterface

>>> hdl/i2cbe_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbe_out_if
// Result word channel: bus levels and command status per tick.
// ----------------------------------------------------------------------------
interface i2cbe_out_if import i2cbe_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  scl_level;
  logic  sda_release;
  logic  busy_res;
  logic  done_res;
  byte_t read_data;
  logic  ack_missing;

  modport source (output valid, output scl_level, output sda_release,
                  output busy_res, output done_res, output read_data,
                  output ack_missing, input ready);
  modport sink   (input valid, input scl_level, input sda_release,
                  input busy_res, input done_res, input read_data,
                  input ack_missing, output ready);
endinterface

>>> hdl/i2cbe_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbe_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface i2cbe_cfg_if import i2cbe_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  cfg_data_t            wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> hdl/i2cbe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbe_front
// Accepts tick words, decodes the command code and registers the word.
// ----------------------------------------------------------------------------
module i2cbe_front import i2cbe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  i2cbe_in_if.sink   in_ch,
  output logic       push_valid,
  input  logic       push_ready,
  output tick_word_t push_word
);

  logic       stage_valid_r;
  logic       stage_valid_nxt;
  tick_word_t stage_word_r;
  tick_word_t stage_word_nxt;
  func_t      cmd;
  logic       take;

  always_comb begin
    unique case (in_ch.func)
      FN_START, FN_STOP, FN_WR_ACK, FN_WR_NOACK, FN_RD_ACK, FN_RD_NACK:
        cmd = func_t'(in_ch.func);
      default: cmd = FN_TICK;
    endcase
  end

  assign in_ch.ready = !stage_valid_r || push_ready;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    stage_word_nxt  = stage_word_r;
    if (take) begin
      stage_valid_nxt     = 1'b1;
      stage_word_nxt.cmd  = cmd;
      stage_word_nxt.data = in_ch.data_byte;
      stage_word_nxt.sda  = in_ch.sda_sample;
    end else if (push_ready) begin
      stage_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
    stage_word_r <= stage_word_nxt;
  end

  assign push_valid = stage_valid_r;
  assign push_word  = stage_word_r;

endmodule

>>> hdl/i2cbe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbe_queue
// Short queue of tick words between the front and the bus engine.
// ----------------------------------------------------------------------------
module i2cbe_queue import i2cbe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  tick_word_t push_word,
  output logic       pop_valid,
  input  logic       pop_ready,
  output tick_word_t pop_word
);

  tick_word_t         mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r;
  logic [Q_CNT_W-1:0] count_nxt;
  logic               do_push;
  logic               do_pop;

  assign push_ready = count_r != Q_CNT_W'(Q_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_word   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_word;
    end
  end

endmodule

>>> hdl/i2cbe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbe_back
// Bus phase engine: one step per tick word, result word registered.
// ----------------------------------------------------------------------------
module i2cbe_back import i2cbe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  tick_word_t pop_word,
  i2cbe_cfg_if.sink  cfg_ch,
  i2cbe_out_if.source out_ch
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_START_C,
    PH_STOP_A, PH_STOP_B, PH_STOP_C,
    PH_WR_SETUP, PH_WR_HIGH, PH_WR_LOW,
    PH_ACK_A, PH_ACK_B, PH_ACK_POLL, PH_ACK_END,
    PH_RD_LOW, PH_RD_HIGH,
    PH_AK_LOW, PH_AK_HIGH, PH_AK_END
  } phase_t;

  localparam longint unsigned CntMax = (64'd1 << COUNTER_WIDTH) - 64'd1;

  cfg_data_t half_delay_r;
  cfg_data_t ack_timeout_r;

  phase_t    phase_r,     phase_nxt;
  cnt_t      tick_r,      tick_nxt;
  logic      halves_r,    halves_nxt;
  logic [3:0] bit_r,      bit_nxt;
  byte_t     shift_r,     shift_nxt;
  func_t     active_r,    active_nxt;
  cfg_data_t tmo_r,       tmo_nxt;
  logic      scl_r,       scl_nxt;
  logic      sda_r,       sda_nxt;
  logic      fail_r,      fail_nxt;
  byte_t     last_rd_r,   last_rd_nxt;
  logic      out_valid_r, out_valid_nxt;

  logic       step;
  logic       go;
  phase_t     go_ph;
  logic [1:0] go_halves;
  logic       done;
  cnt_t       half_len;
  cnt_t       cnt_dec;
  logic [3:0] bit_inc;

  always_comb begin
    if (half_delay_r == '0) begin
      half_len = cnt_t'(1);
    end else if (64'(half_delay_r) > CntMax) begin
      half_len = cnt_t'(CntMax);
    end else begin
      half_len = cnt_t'(half_delay_r);
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign pop_ready    = !out_valid_r || out_ch.ready;
  assign step         = pop_valid && pop_ready;
  assign cnt_dec      = tick_r - 1'b1;
  assign bit_inc      = bit_r + 1'b1;

  always_comb begin
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    halves_nxt  = halves_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    active_nxt  = active_r;
    tmo_nxt     = tmo_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    fail_nxt    = fail_r;
    last_rd_nxt = last_rd_r;
    go          = 1'b0;
    go_ph       = PH_IDLE;
    go_halves   = 2'd0;
    done        = 1'b0;

    if (phase_r == PH_IDLE) begin
      if (pop_word.cmd != FN_TICK) begin
        active_nxt = pop_word.cmd;
        bit_nxt    = '0;
        fail_nxt   = 1'b0;
        tmo_nxt    = '0;
        go         = 1'b1;
        unique case (pop_word.cmd)
          FN_START: begin
            go_ph = PH_START_A; go_halves = 2'd2;
          end
          FN_STOP: begin
            go_ph = PH_STOP_A; go_halves = 2'd2;
          end
          FN_WR_ACK, FN_WR_NOACK: begin
            shift_nxt = pop_word.data; go_ph = PH_WR_SETUP; go_halves = 2'd1;
          end
          default: begin
            shift_nxt = '0; go_ph = PH_RD_LOW; go_halves = 2'd2;
          end
        endcase
      end
    end else if (phase_r == PH_ACK_POLL) begin
      if (!pop_word.sda) begin
        go = 1'b1; go_ph = PH_ACK_END; go_halves = 2'd2;
      end else if (tmo_r >= ack_timeout_r) begin
        fail_nxt = 1'b1;
        go = 1'b1; go_ph = PH_STOP_A; go_halves = 2'd2;
      end else begin
        tmo_nxt = tmo_r + 1'b1;
      end
    end else begin
      tick_nxt = cnt_dec;
      if (cnt_dec == '0) begin
        if (halves_r) begin
          halves_nxt = 1'b0;
          tick_nxt   = half_len;
        end else begin
          go = 1'b1;
          unique case (phase_r)
            PH_START_A:  begin go_ph = PH_START_B; go_halves = 2'd2; end
            PH_START_B:  begin go_ph = PH_START_C; go_halves = 2'd1; end
            PH_STOP_A:   begin go_ph = PH_STOP_B;  go_halves = 2'd1; end
            PH_STOP_B:   begin go_ph = PH_STOP_C;  go_halves = 2'd0; end
            PH_WR_SETUP: begin go_ph = PH_WR_HIGH; go_halves = 2'd2; end
            PH_WR_HIGH:  begin go_ph = PH_WR_LOW;  go_halves = 2'd1; end
            PH_WR_LOW: begin
              bit_nxt = bit_inc;
              if (bit_inc < 4'd8) begin
                go_ph = PH_WR_SETUP; go_halves = 2'd1;
              end else if (active_r == FN_WR_ACK) begin
                go_ph = PH_ACK_A; go_halves = 2'd2;
              end else begin
                go = 1'b0; done = 1'b1;
              end
            end
            PH_ACK_A:    begin go_ph = PH_ACK_B;    go_halves = 2'd2; end
            PH_ACK_B:    begin go_ph = PH_ACK_POLL; go_halves = 2'd1; end
            PH_RD_LOW:   begin go_ph = PH_RD_HIGH;  go_halves = 2'd2; end
            PH_RD_HIGH: begin
              shift_nxt = {shift_r[BYTE_W-2:0], pop_word.sda};
              bit_nxt   = bit_inc;
              if (bit_inc < 4'd8) begin
                go_ph = PH_RD_LOW; go_halves = 2'd2;
              end else begin
                last_rd_nxt = {shift_r[BYTE_W-2:0], pop_word.sda};
                go_ph = PH_AK_LOW; go_halves = 2'd2;
              end
            end
            PH_AK_LOW:   begin go_ph = PH_AK_HIGH; go_halves = 2'd2; end
            PH_AK_HIGH:  begin go_ph = PH_AK_END;  go_halves = 2'd0; end
            default: begin
              go = 1'b0; done = 1'b1;
            end
          endcase
        end
      end
    end

    if (go) begin
      phase_nxt = go_ph;
      if (go_halves == 2'd0) begin
        tick_nxt   = cnt_t'(1);
        halves_nxt = 1'b0;
      end else begin
        tick_nxt   = half_len;
        halves_nxt = (go_halves == 2'd2);
      end
      unique case (go_ph)
        PH_START_A:  begin scl_nxt = 1'b1; sda_nxt = 1'b1; end
        PH_START_B:  sda_nxt = 1'b0;
        PH_START_C:  scl_nxt = 1'b0;
        PH_STOP_A:   begin scl_nxt = 1'b0; sda_nxt = 1'b0; end
        PH_STOP_B:   scl_nxt = 1'b1;
        PH_STOP_C:   sda_nxt = 1'b1;
        PH_WR_SETUP: begin
          scl_nxt   = 1'b0;
          sda_nxt   = shift_nxt[BYTE_W-1];
          shift_nxt = {shift_nxt[BYTE_W-2:0], 1'b0};
        end
        PH_WR_HIGH:  scl_nxt = 1'b1;
        PH_WR_LOW:   scl_nxt = 1'b0;
        PH_ACK_A:    begin scl_nxt = 1'b0; sda_nxt = 1'b1; end
        PH_ACK_B:    scl_nxt = 1'b1;
        PH_ACK_POLL: tmo_nxt = '0;
        PH_ACK_END:  scl_nxt = 1'b0;
        PH_RD_LOW:   begin scl_nxt = 1'b0; sda_nxt = 1'b1; end
        PH_RD_HIGH:  scl_nxt = 1'b1;
        PH_AK_LOW: begin
          scl_nxt = 1'b0;
          sda_nxt = (active_r != FN_RD_ACK);
        end
        PH_AK_HIGH:  scl_nxt = 1'b1;
        PH_AK_END:   scl_nxt = 1'b0;
        default: ;
      endcase
    end

    if (done) begin
      phase_nxt  = PH_IDLE;
      tick_nxt   = '0;
      halves_nxt = 1'b0;
    end
  end

  always_comb begin
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_delay_r  <= cfg_data_t'(5);
      ack_timeout_r <= cfg_data_t'(1024);
      phase_r       <= PH_IDLE;
      tick_r        <= '0;
      halves_r      <= 1'b0;
      bit_r         <= '0;
      shift_r       <= '0;
      active_r      <= FN_TICK;
      tmo_r         <= '0;
      scl_r         <= 1'b1;
      sda_r         <= 1'b1;
      fail_r        <= 1'b0;
      last_rd_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_idx_t'(cfg_ch.index))
          REG_HALF_DELAY:  half_delay_r  <= cfg_ch.wdata;
          REG_ACK_TIMEOUT: ack_timeout_r <= cfg_ch.wdata;
          default: ;
        endcase
      end
      if (step) begin
        phase_r   <= phase_nxt;
        tick_r    <= tick_nxt;
        halves_r  <= halves_nxt;
        bit_r     <= bit_nxt;
        shift_r   <= shift_nxt;
        active_r  <= active_nxt;
        tmo_r     <= tmo_nxt;
        scl_r     <= scl_nxt;
        sda_r     <= sda_nxt;
        fail_r    <= fail_nxt;
        last_rd_r <= last_rd_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (step) begin
      out_ch.scl_level   <= scl_nxt;
      out_ch.sda_release <= sda_nxt;
      out_ch.busy_res    <= (phase_nxt != PH_IDLE);
      out_ch.done_res    <= done;
      out_ch.read_data   <= last_rd_nxt;
      out_ch.ack_missing <= done && fail_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule

>>> hdl/i2c_master_bit_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core
// I2C master bit engine stepped by tick words.
// ----------------------------------------------------------------------------
// Every accepted word is one bus tick and yields exactly one result word with
// the SCL/SDA levels and command status for that tick. A tick taken while the
// engine is idle may start START, STOP, byte write (with or without ACK wait)
// or byte read (sending ACK or NACK). One word is accepted per clock unless
// the output side holds back the pipe; a word passes the front register, the
// two-entry queue and then the result register that the engine step loads,
// so sustained throughput is one word per cycle when neither side stalls, with
// either side able to stall independently. Registers: index 0 half delay in
// ticks (0 acts as 1), index 1 ACK timeout in ticks; write them only while the
// engine is idle.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core import i2cbe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  i2cbe_in_if.sink    in_ch,
  i2cbe_out_if.source out_ch,
  i2cbe_cfg_if.sink   cfg_ch
);

  logic       push_valid;
  logic       push_ready;
  tick_word_t push_word;
  logic       pop_valid;
  logic       pop_ready;
  tick_word_t pop_word;

  i2cbe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word)
  );

  i2cbe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_word   (pop_word)
  );

  i2cbe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_word  (pop_word),
    .cfg_ch    (cfg_ch),
    .out_ch    (out_ch)
  );

endmodule

>>> bench/tb_i2c_master_bit_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_bit_engine_core
// Self-checking bench for the I2C master bit engine.
// Tick words come from a pending queue through a clocked driver. Each
// accepted word steps a bit-exact engine model, and the model's bus levels
// and status are queued. A clocked monitor checks every result word against
// that queue. Directed commands come first, then random START/write/read/STOP
// transactions with noise. The half delay and ACK timeout change between
// phases, extremes included. Both sides stall at random and under pressure.
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_engine_core;
  import i2cbe_pkg::*;

  localparam int          HOLD_CYCLES  = 300;
  localparam int          WDOG_LIMIT   = 2000;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          DRAIN_CYCLES = 10;
  localparam int          MAX_REPORTS  = 10;

  typedef enum logic [4:0] {
    BP_IDLE, BP_START_A, BP_START_B, BP_START_C,
    BP_STOP_A, BP_STOP_B, BP_STOP_C,
    BP_WR_SETUP, BP_WR_HIGH, BP_WR_LOW,
    BP_ACK_A, BP_ACK_B, BP_ACK_POLL, BP_ACK_END,
    BP_RD_LOW, BP_RD_HIGH,
    BP_AK_LOW, BP_AK_HIGH, BP_AK_END
  } bus_phase_t;

  typedef struct packed {
    bus_phase_t  ph;
    cnt_t        ticks_left;
    logic [1:0]  halves_left;
    logic [3:0]  bit_idx;
    byte_t       shreg;
    logic [2:0]  cmd;
    logic [15:0] poll_cnt;
    logic        scl;
    logic        sda;
    logic        fail;
    logic        done;
    byte_t       last_rd;
  } engine_t;

  typedef struct packed {
    logic [2:0] func;
    byte_t      data;
    logic       sda;
  } tick_item_t;

  typedef struct packed {
    logic  scl;
    logic  sda;
    logic  busy;
    logic  done;
    byte_t rd;
    logic  nack;
  } bus_levels_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic       in_vld  = 1'b0;
  logic [2:0] in_func = 3'd0;
  byte_t      in_data = '0;
  logic       in_sda  = 1'b1;
  logic       out_rdy = 1'b0;
  logic       cfg_vld = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  cfg_data_t  cfg_wd  = '0;

  cfg_data_t  half_ticks = 16'd5;
  cfg_data_t  ack_limit  = 16'd1024;

  int unsigned snd_idle_pct = 19;
  int unsigned rcv_idle_pct = 57;
  int unsigned hold_reqs    = 0;
  int unsigned hold_seen    = 0;
  int unsigned rx_hold_left = 0;
  int unsigned idle_cycles  = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned plan_ticks   = 0;

  tick_item_t  tick_q[$];
  bus_levels_t levels_q[$];
  engine_t     eng_now;
  engine_t     eng_plan;

  i2cbe_in_if  in_ch ();
  i2cbe_out_if out_ch ();
  i2cbe_cfg_if cfg_ch ();

  assign in_ch.valid      = in_vld;
  assign in_ch.func       = in_func;
  assign in_ch.data_byte  = in_data;
  assign in_ch.sda_sample = in_sda;
  assign out_ch.ready     = out_rdy;
  assign cfg_ch.valid     = cfg_vld;
  assign cfg_ch.index     = cfg_idx;
  assign cfg_ch.wdata     = cfg_wd;

  i2c_master_bit_engine_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic engine_t engine_reset();
    engine_t s;
    s         = '0;
    s.ph      = BP_IDLE;
    s.scl     = 1'b1;
    s.sda     = 1'b1;
    return s;
  endfunction

  function automatic cnt_t half_len();
    return (half_ticks == '0) ? cnt_t'(1) : cnt_t'(half_ticks);
  endfunction

  // halves == 0: single-tick phase
  function automatic engine_t enter_phase(engine_t s, bus_phase_t p, int halves);
    s.ph = p;
    if (halves == 0) begin
      s.ticks_left  = cnt_t'(1);
      s.halves_left = '0;
    end else begin
      s.ticks_left  = half_len();
      s.halves_left = 2'(halves - 1);
    end
    case (p)
      BP_START_A: begin
        s.scl = 1'b1;
        s.sda = 1'b1;
      end
      BP_START_B: s.sda = 1'b0;
      BP_START_C: s.scl = 1'b0;
      BP_STOP_A: begin
        s.scl = 1'b0;
        s.sda = 1'b0;
      end
      BP_STOP_B: s.scl = 1'b1;
      BP_STOP_C: s.sda = 1'b1;
      BP_WR_SETUP: begin
        s.scl   = 1'b0;
        s.sda   = s.shreg[7];
        s.shreg = {s.shreg[6:0], 1'b0};
      end
      BP_WR_HIGH: s.scl = 1'b1;
      BP_WR_LOW: s.scl = 1'b0;
      BP_ACK_A: begin
        s.scl = 1'b0;
        s.sda = 1'b1;
      end
      BP_ACK_B: s.scl = 1'b1;
      BP_ACK_POLL: s.poll_cnt = '0;
      BP_ACK_END: s.scl = 1'b0;
      BP_RD_LOW: begin
        s.scl = 1'b0;
        s.sda = 1'b1;
      end
      BP_RD_HIGH: s.scl = 1'b1;
      BP_AK_LOW: begin
        s.scl = 1'b0;
        s.sda = (s.cmd == FN_RD_ACK) ? 1'b0 : 1'b1;
      end
      BP_AK_HIGH: s.scl = 1'b1;
      BP_AK_END: s.scl = 1'b0;
      default: ;
    endcase
    return s;
  endfunction

  function automatic engine_t engine_step(engine_t s, logic [2:0] f, byte_t d,
                                          logic sda_in);
    logic fin;
    fin    = 1'b0;
    s.done = 1'b0;
    if (s.ph == BP_IDLE) begin
      if (f >= FN_START && f <= FN_RD_NACK) begin
        s.cmd      = f;
        s.bit_idx  = '0;
        s.fail     = 1'b0;
        s.poll_cnt = '0;
        case (f)
          FN_START: s = enter_phase(s, BP_START_A, 2);
          FN_STOP:  s = enter_phase(s, BP_STOP_A, 2);
          FN_WR_ACK, FN_WR_NOACK: begin
            s.shreg = d;
            s = enter_phase(s, BP_WR_SETUP, 1);
          end
          default: begin
            s.shreg = '0;
            s = enter_phase(s, BP_RD_LOW, 2);
          end
        endcase
      end
    end else if (s.ph == BP_ACK_POLL) begin
      if (!sda_in) begin
        s = enter_phase(s, BP_ACK_END, 2);
      end else if (s.poll_cnt >= ack_limit) begin
        s.fail = 1'b1;
        s = enter_phase(s, BP_STOP_A, 2);
      end else begin
        s.poll_cnt = s.poll_cnt + 16'd1;
      end
    end else begin
      s.ticks_left = s.ticks_left - cnt_t'(1);
      if (s.ticks_left == '0) begin
        if (s.halves_left != '0) begin
          s.halves_left = s.halves_left - 2'd1;
          s.ticks_left  = half_len();
        end else begin
          case (s.ph)
            BP_START_A:  s = enter_phase(s, BP_START_B, 2);
            BP_START_B:  s = enter_phase(s, BP_START_C, 1);
            BP_STOP_A:   s = enter_phase(s, BP_STOP_B, 1);
            BP_STOP_B:   s = enter_phase(s, BP_STOP_C, 0);
            BP_WR_SETUP: s = enter_phase(s, BP_WR_HIGH, 2);
            BP_WR_HIGH:  s = enter_phase(s, BP_WR_LOW, 1);
            BP_WR_LOW: begin
              s.bit_idx = s.bit_idx + 4'd1;
              if (s.bit_idx < 4'd8) s = enter_phase(s, BP_WR_SETUP, 1);
              else if (s.cmd == FN_WR_ACK) s = enter_phase(s, BP_ACK_A, 2);
              else fin = 1'b1;
            end
            BP_ACK_A:    s = enter_phase(s, BP_ACK_B, 2);
            BP_ACK_B:    s = enter_phase(s, BP_ACK_POLL, 1);
            BP_RD_LOW:   s = enter_phase(s, BP_RD_HIGH, 2);
            BP_RD_HIGH: begin
              s.shreg   = {s.shreg[6:0], sda_in};
              s.bit_idx = s.bit_idx + 4'd1;
              if (s.bit_idx < 4'd8) begin
                s = enter_phase(s, BP_RD_LOW, 2);
              end else begin
                s.last_rd = s.shreg;
                s = enter_phase(s, BP_AK_LOW, 2);
              end
            end
            BP_AK_LOW:   s = enter_phase(s, BP_AK_HIGH, 2);
            BP_AK_HIGH:  s = enter_phase(s, BP_AK_END, 0);
            default:     fin = 1'b1;
          endcase
          if (fin) begin
            s.ph          = BP_IDLE;
            s.ticks_left  = '0;
            s.halves_left = '0;
            s.done        = 1'b1;
          end
        end
      end
    end
    return s;
  endfunction

  function automatic bus_levels_t levels_of(engine_t s);
    bus_levels_t r;
    r.scl  = s.scl;
    r.sda  = s.sda;
    r.busy = (s.ph != BP_IDLE);
    r.done = s.done;
    r.rd   = s.last_rd;
    r.nack = s.done & s.fail;
    return r;
  endfunction

  function automatic byte_t rand_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return byte_t'($urandom);
    endcase
  endfunction

  // high samples before the slave acks; -1 never acks
  function automatic int pick_ack_wait();
    if (ack_limit <= 16 && $urandom_range(3) == 0) return -1;
    return $urandom_range(6);
  endfunction

  task automatic push_tick(logic [2:0] f, byte_t d, logic sda);
    tick_item_t it;
    it.func  = f;
    it.data  = d;
    it.sda   = sda;
    eng_plan = engine_step(eng_plan, f, d, sda);
    tick_q.push_back(it);
    plan_ticks++;
  endtask

  // command tick, then ticks with bus-side SDA until the engine is idle
  task automatic run_cmd(logic [2:0] f, byte_t d, int ack_wait);
    int   polls;
    logic sda;
    polls = 0;
    push_tick(f, d, 1'($urandom_range(1)));
    while (eng_plan.ph != BP_IDLE) begin
      if (eng_plan.ph == BP_ACK_POLL) begin
        sda = !(ack_wait >= 0 && polls >= ack_wait);
        polls++;
      end else begin
        sda = 1'($urandom_range(1));
      end
      push_tick(($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'(FN_TICK),
                byte_t'($urandom), sda);
    end
  endtask

  task automatic rand_phase(int n);
    int   target;
    int   k;
    logic rd;
    target = plan_ticks + n;
    while (plan_ticks < target) begin
      if ($urandom_range(3) != 0) begin
        run_cmd(FN_START, rand_byte(), 0);
        run_cmd(FN_WR_ACK, rand_byte(), pick_ack_wait());
        k  = $urandom_range(1, 3);
        rd = 1'($urandom_range(1));
        for (int i = 0; i < k; i++) begin
          if (rd) run_cmd((i == k - 1) ? FN_RD_NACK : FN_RD_ACK, rand_byte(), 0);
          else run_cmd($urandom_range(1) ? FN_WR_ACK : FN_WR_NOACK, rand_byte(),
                       pick_ack_wait());
        end
        run_cmd(FN_STOP, rand_byte(), 0);
      end else begin
        run_cmd(3'($urandom_range(7)), rand_byte(), pick_ack_wait());
      end
    end
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || levels_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, cfg_data_t val);
    @(posedge clk);
    cfg_vld <= 1'b1;
    cfg_idx <= idx;
    cfg_wd  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_vld <= 1'b0;
    if (idx == REG_HALF_DELAY) half_ticks = val;
    else ack_limit = val;
    @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    logic sent;
    sent = 1'b0;
    if (!rst_n) begin
      in_vld <= 1'b0;
    end else begin
      if (in_vld && in_ch.ready) begin
        eng_now = engine_step(eng_now, tick_q[0].func, tick_q[0].data, tick_q[0].sda);
        levels_q.push_back(levels_of(eng_now));
        void'(tick_q.pop_front());
        sent = 1'b1;
      end
      if (!in_vld || sent) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          in_vld  <= 1'b1;
          in_func <= tick_q[0].func;
          in_data <= tick_q[0].data;
          in_sda  <= tick_q[0].sda;
        end else begin
          in_vld <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    bus_levels_t got;
    bus_levels_t want;
    if (rst_n) begin
      if (out_rdy && out_ch.valid === 1'b1) begin
        got.scl  = out_ch.scl_level;
        got.sda  = out_ch.sda_release;
        got.busy = out_ch.busy_res;
        got.done = out_ch.done_res;
        got.rd   = out_ch.read_data;
        got.nack = out_ch.ack_missing;
        if (levels_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("unexpected result word: scl=%0b sda=%0b busy=%0b done=%0b",
                     got.scl, got.sda, got.busy, got.done);
        end else begin
          want = levels_q.pop_front();
          if (got.scl !== want.scl || got.sda !== want.sda || got.busy !== want.busy ||
              got.done !== want.done || got.rd !== want.rd || got.nack !== want.nack) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("mismatch exp scl=%0b sda=%0b busy=%0b done=%0b rd=%02h nack=%0b %s",
                       want.scl, want.sda, want.busy, want.done, want.rd, want.nack,
                       $sformatf("got scl=%0b sda=%0b busy=%0b done=%0b rd=%02h nack=%0b",
                                 got.scl, got.sda, got.busy, got.done, got.rd,
                                 got.nack));
          end
        end
      end
      out_rdy <= (rx_hold_left == 0) && ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // receiver hold-off
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen    <= hold_reqs;
      rx_hold_left <= HOLD_CYCLES;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_vld && in_ch.ready) || (out_rdy && out_ch.valid === 1'b1) ||
        (cfg_vld && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    eng_now  = engine_reset();
    eng_plan = engine_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings
    run_cmd(FN_START, 8'h00, 0);
    run_cmd(FN_WR_ACK, 8'h5A, 2);
    run_cmd(FN_STOP, 8'hFF, 0);
    wait_drained();

    // fast bus, short timeout: missing ack runs it out
    cfg_write(REG_HALF_DELAY, 16'd1);
    cfg_write(REG_ACK_TIMEOUT, 16'd3);
    run_cmd(FN_TICK, 8'hFF, 0);
    run_cmd(3'd7, 8'h00, 0);
    run_cmd(FN_START, 8'h00, 0);
    run_cmd(FN_WR_ACK, 8'hFF, 0);
    run_cmd(FN_WR_ACK, 8'h00, -1);
    run_cmd(FN_START, 8'h00, 0);
    run_cmd(FN_WR_NOACK, 8'hA5, 0);
    run_cmd(FN_RD_ACK, 8'hFF, 0);
    run_cmd(FN_RD_NACK, 8'h00, 0);
    run_cmd(FN_STOP, 8'h00, 0);
    run_cmd(FN_STOP, 8'hFF, 0);
    wait_drained();

    // zero half delay and zero timeout, receiver backs up the pipe
    cfg_write(REG_HALF_DELAY, 16'd0);
    cfg_write(REG_ACK_TIMEOUT, 16'd0);
    rand_phase(80);
    hold_reqs++;
    wait_drained();

    snd_idle_pct = 57;
    rcv_idle_pct = 19;
    cfg_write(REG_HALF_DELAY, 16'd2);
    cfg_write(REG_ACK_TIMEOUT, 16'd4);
    rand_phase(50);
    wait_drained();

    // sender pauses mid-phase until the pipe is empty
    cfg_write(REG_HALF_DELAY, 16'd1);
    cfg_write(REG_ACK_TIMEOUT, 16'd1);
    rand_phase(30);
    wait_drained();
    rand_phase(30);
    wait_drained();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    cfg_write(REG_HALF_DELAY, 16'd1);
    cfg_write(REG_ACK_TIMEOUT, 16'd2);
    rand_phase(30);
    wait_drained();

    cfg_write(REG_HALF_DELAY, 16'hFFFF);
    cfg_write(REG_ACK_TIMEOUT, 16'hFFFF);
    run_cmd(FN_TICK, 8'h00, 0);
    run_cmd(3'd7, 8'hFF, 0);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && levels_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
